@@ rtl/core/iida_pkg.sv @@
`default_nettype none

package iida_pkg;

    // Default depth of the array
    localparam int CAPACITY_DEF = 256;
    // Position width inside the cell chain; covers the largest supported depth
    localparam int POS_W        = 13;
    // Cells per group of the read gather tree
    localparam int GROUP        = 16;

    localparam int DATA_W  = 64;
    localparam int IDX_W   = 9;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 9;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_DELETE = 3'd4,
        OP_SIZE   = 3'd5
    } op_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_SIZE  = 2'd3
    } status_t;

    // What every cell does in this cycle
    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_READ,
        MODE_WRITE,
        MODE_INSERT,
        MODE_DELETE,
        MODE_FILL
    } mode_t;

    // Broadcast control from the sequencer to the chain
    typedef struct packed {
        mode_t              mode;
        logic [POS_W-1:0]   lo;
        logic [POS_W-1:0]   hi;
        logic [DATA_W-1:0]  value;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/iida_cell.sv @@
`default_nettype none

module iida_cell #(
    parameter int POS = 0
) (
    input  wire logic                         aclk,
    input  wire iida_pkg::cell_ctl_t          ctl,
    input  wire logic [iida_pkg::DATA_W-1:0]  left_word,
    input  wire logic [iida_pkg::DATA_W-1:0]  right_word,
    output logic      [iida_pkg::DATA_W-1:0]  word,
    output logic      [iida_pkg::DATA_W-1:0]  rd_word
);

    localparam logic [iida_pkg::POS_W-1:0] POS_V = iida_pkg::POS_W'(POS);

    logic [iida_pkg::DATA_W-1:0] word_reg;
    logic [iida_pkg::DATA_W-1:0] word_next;
    logic                        at_lo;
    logic                        above_lo;
    logic                        below_hi;

    assign at_lo    = (POS_V == ctl.lo);
    assign above_lo = (POS_V > ctl.lo);
    assign below_hi = (POS_V < ctl.hi);

    // Next word: own, neighbor, broadcast value or zero fill
    always_comb begin
        word_next = word_reg;
        unique case (ctl.mode)
            iida_pkg::MODE_WRITE: begin
                if (at_lo) word_next = ctl.value;
            end
            iida_pkg::MODE_INSERT: begin
                if (at_lo)         word_next = ctl.value;
                else if (above_lo) word_next = left_word;
            end
            iida_pkg::MODE_DELETE: begin
                if (at_lo || above_lo) word_next = right_word;
            end
            iida_pkg::MODE_FILL: begin
                if ((at_lo || above_lo) && below_hi) word_next = '0;
            end
            default: word_next = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    // Read tap, zero unless this cell is addressed
    assign rd_word = (ctl.mode == iida_pkg::MODE_READ && at_lo) ? word_reg : '0;
    assign word    = word_reg;

endmodule

`default_nettype wire

@@ rtl/core/indexed_insert_delete_array.sv @@
`default_nettype none

// Channel | Dir | Ports                      | Fields (lowest bit first)
// s_      | in  | s_tvalid s_tready s_tdata  | op[2:0] index[11:3] value[75:12] new_size[84:76]
// m_      | out | m_tvalid m_tready m_tdata  | status[1:0] read_data[65:2] count[74:66]
//
// Every request, inserts and deletes included, takes effect in the cell chain at the
// edge that accepts it: each cell loads its neighbor's word in the same edge. One request
// per cycle is taken unless a stalled result fills the gather stage. A read is gathered
// over two registered levels: the group partials, then their OR in the output register.
// Reset clears the count and the handshake state; the stored words stay undefined.
// A stalled result holds in the output register and backs up through the gather stage.

module indexed_insert_delete_array #(
    parameter int CAPACITY = iida_pkg::CAPACITY_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,   // op, index, value, new_size
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [79:0] m_tdata    // status, read_data, count
);

    localparam int LW   = $clog2(CAPACITY + 1);
    localparam int NGRP = (CAPACITY + iida_pkg::GROUP - 1) / iida_pkg::GROUP;
    localparam logic [iida_pkg::POS_W-1:0] CAP_V = iida_pkg::POS_W'(CAPACITY);

    // Request fields
    logic [iida_pkg::OP_W-1:0]   req_op;
    logic [iida_pkg::IDX_W-1:0]  req_index;
    logic [iida_pkg::DATA_W-1:0] req_value;
    logic [iida_pkg::IDX_W-1:0]  req_size;

    assign req_op    = s_tdata[2:0];
    assign req_index = s_tdata[11:3];
    assign req_value = s_tdata[75:12];
    assign req_size  = s_tdata[84:76];

    logic [LW-1:0]                live_reg;
    logic [LW-1:0]                live_next;
    logic                         p_valid_reg;
    logic [iida_pkg::STAT_W-1:0]  p_status_reg;
    logic [LW-1:0]                p_count_reg;
    logic [iida_pkg::DATA_W-1:0]  part_reg  [NGRP];
    logic [iida_pkg::DATA_W-1:0]  part_next [NGRP];
    logic                         m_valid_reg;
    logic [79:0]                  m_tdata_reg;

    logic s_fire;
    logic out_free;
    logic p_adv;

    assign out_free = !m_valid_reg || m_tready;
    assign p_adv    = p_valid_reg && out_free;
    assign s_tready = !p_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    // Decode a request against the current count
    iida_pkg::cell_ctl_t          ctl;
    iida_pkg::status_t            status;
    logic [iida_pkg::POS_W-1:0]   idx_w;
    logic [iida_pkg::POS_W-1:0]   live_w;
    logic [iida_pkg::POS_W-1:0]   size_w;

    assign idx_w  = iida_pkg::POS_W'(req_index);
    assign live_w = iida_pkg::POS_W'(live_reg);
    assign size_w = iida_pkg::POS_W'(req_size);

    always_comb begin
        iida_pkg::mode_t mode;
        mode      = iida_pkg::MODE_NONE;
        status    = iida_pkg::ST_OK;
        live_next = live_reg;
        ctl.lo    = idx_w;
        ctl.hi    = size_w;
        ctl.value = req_value;
        unique case (req_op)
            iida_pkg::OP_READ: begin
                if (idx_w < live_w) mode = iida_pkg::MODE_READ;
                else                status = iida_pkg::ST_BAD_INDEX;
            end
            iida_pkg::OP_WRITE: begin
                if (idx_w < live_w) mode = iida_pkg::MODE_WRITE;
                else                status = iida_pkg::ST_BAD_INDEX;
            end
            iida_pkg::OP_APPEND: begin
                if (live_w >= CAP_V) begin
                    status = iida_pkg::ST_FULL;
                end else begin
                    mode      = iida_pkg::MODE_WRITE;
                    ctl.lo    = live_w;
                    live_next = live_reg + LW'(1);
                end
            end
            iida_pkg::OP_INSERT: begin
                if (idx_w > live_w) begin
                    status = iida_pkg::ST_BAD_INDEX;
                end else if (live_w >= CAP_V) begin
                    status = iida_pkg::ST_FULL;
                end else begin
                    mode      = iida_pkg::MODE_INSERT;
                    live_next = live_reg + LW'(1);
                end
            end
            iida_pkg::OP_DELETE: begin
                if (idx_w >= live_w) begin
                    status = iida_pkg::ST_BAD_INDEX;
                end else begin
                    mode      = iida_pkg::MODE_DELETE;
                    live_next = live_reg - LW'(1);
                end
            end
            iida_pkg::OP_SIZE: begin
                if (size_w == '0 || size_w > CAP_V) begin
                    status = iida_pkg::ST_BAD_SIZE;
                end else begin
                    mode      = iida_pkg::MODE_FILL;
                    ctl.lo    = live_w;
                    live_next = LW'(size_w);
                end
            end
            default: ;
        endcase
        ctl.mode = s_fire ? mode : iida_pkg::MODE_NONE;
    end

    // Cell chain
    logic [iida_pkg::DATA_W-1:0] words [CAPACITY];
    logic [iida_pkg::DATA_W-1:0] taps  [NGRP*iida_pkg::GROUP];

    for (genvar i = 0; i < NGRP*iida_pkg::GROUP; i++) begin : g_cell
        if (i < CAPACITY) begin : g_live
            logic [iida_pkg::DATA_W-1:0] left_w;
            logic [iida_pkg::DATA_W-1:0] right_w;
            if (i == 0) begin : g_first
                assign left_w = '0;
            end else begin : g_mid_l
                assign left_w = words[i-1];
            end
            if (i == CAPACITY-1) begin : g_last
                assign right_w = words[i];
            end else begin : g_mid_r
                assign right_w = words[i+1];
            end
            iida_cell #(.POS(i)) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .left_word  (left_w),
                .right_word (right_w),
                .word       (words[i]),
                .rd_word    (taps[i])
            );
        end else begin : g_pad
            assign taps[i] = '0;
        end
    end

    // First gather level: OR of the taps in each group
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            part_next[g] = '0;
            for (int j = 0; j < iida_pkg::GROUP; j++) begin
                part_next[g] = part_next[g] | taps[g*iida_pkg::GROUP + j];
            end
        end
    end

    // Second gather level: OR of the group partials
    logic [iida_pkg::DATA_W-1:0] rd_data;
    always_comb begin
        rd_data = '0;
        for (int g = 0; g < NGRP; g++) begin
            rd_data = rd_data | part_reg[g];
        end
    end

    // Count and handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg    <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) live_reg <= live_next;
            if (s_fire)     p_valid_reg <= 1'b1;
            else if (p_adv) p_valid_reg <= 1'b0;
            if (p_adv)         m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p_status_reg <= status;
            p_count_reg  <= live_next;
            part_reg     <= part_next;
        end
        if (p_adv) begin
            m_tdata_reg <= {5'd0, iida_pkg::COUNT_W'(p_count_reg), rd_data, p_status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        LW'(live_reg) <= LW'(CAPACITY))
        else $error("live count above capacity");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != iida_pkg::ST_OK |-> m_tdata[65:2] == '0)
        else $error("read data not zero on error");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && req_op == iida_pkg::OP_APPEND && live_w < CAP_V
        |=> live_reg == $past(live_reg) + LW'(1))
        else $error("append did not grow the count");

    a_gather_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg && !out_free |=> p_valid_reg && $stable(p_count_reg))
        else $error("gather stage lost a stalled result");

endmodule

`default_nettype wire
